// File: rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

  localparam int unsigned StackDepth = 128;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned KindW      = 4;
  localparam int unsigned DepthW     = 8;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH  = 4'd0,
    KIND_ADD   = 4'd1,
    KIND_SUB   = 4'd2,
    KIND_MUL   = 4'd3,
    KIND_DIV   = 4'd4,
    KIND_MOD   = 4'd5,
    KIND_CLEAR = 4'd6,
    KIND_PEEK  = 4'd7,
    KIND_DUP   = 4'd8,
    KIND_SWAP  = 4'd9,
    KIND_EOL   = 4'd10,
    KIND_BAD   = 4'd11
  } kind_e;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_BINARY,
    OP_CLEAR,
    OP_PEEK,
    OP_DUP,
    OP_SWAP,
    OP_EOL,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    AR_ADD,
    AR_SUB,
    AR_MUL,
    AR_DIVMOD
  } arith_e;

  // A classified token as it sits in the queue.
  typedef struct packed {
    op_e               op;
    arith_e            arith;
    logic              is_mod;
    logic [DataW-1:0]  operand;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_B,
    ST_WAIT_B,
    ST_RD_A,
    ST_WAIT_A,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIN,
    ST_WRITE2,
    ST_DONE
  } state_e;

  function automatic logic [DataW-1:0] sat64(input logic signed [65:0] v);
    logic [DataW-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rpn_front.sv
`default_nettype none
module rpn_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [3:0]         kind_i,
  input  wire logic [31:0]        operand_i,
  output logic                    busy_o,
  output rpn_pkg::cmd_t           cmd_o,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_pop_i
);
  import rpn_pkg::*;

  // Two-entry queue between token intake and execution.
  cmd_t        q_mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  cmd_t        cmd_d;
  logic        push;

  always_comb begin
    cmd_d = '0;
    cmd_d.operand = operand_i;
    unique case (kind_i)
      KIND_PUSH:  cmd_d.op = OP_PUSH;
      KIND_ADD:   begin cmd_d.op = OP_BINARY; cmd_d.arith = AR_ADD; end
      KIND_SUB:   begin cmd_d.op = OP_BINARY; cmd_d.arith = AR_SUB; end
      KIND_MUL:   begin cmd_d.op = OP_BINARY; cmd_d.arith = AR_MUL; end
      KIND_DIV:   begin cmd_d.op = OP_BINARY; cmd_d.arith = AR_DIVMOD; end
      KIND_MOD:   begin
        cmd_d.op = OP_BINARY; cmd_d.arith = AR_DIVMOD; cmd_d.is_mod = 1'b1;
      end
      KIND_CLEAR: cmd_d.op = OP_CLEAR;
      KIND_PEEK:  cmd_d.op = OP_PEEK;
      KIND_DUP:   cmd_d.op = OP_DUP;
      KIND_SWAP:  cmd_d.op = OP_SWAP;
      KIND_EOL:   cmd_d.op = OP_EOL;
      default:    cmd_d.op = OP_BAD;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

// File: rtl/rpn_divider.sv
`default_nettype none
module rpn_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quot_o,
  output logic [31:0]      rem_o
);
  import rpn_pkg::*;

  // Unsigned restoring divider, one quotient bit per cycle.
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quot_q[63]} - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = 7'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[31:0];

endmodule
`default_nettype wire

// File: rtl/rpn_back.sv
`default_nettype none
module rpn_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rpn_pkg::cmd_t   cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_pop_o,
  output logic                 strobe_o,
  output logic [31:0]          answer_o,
  output logic                 answer_valid_o,
  output logic                 underflow_o,
  output logic                 overflow_o,
  output logic                 div_zero_o,
  output logic [7:0]           depth_o
);
  import rpn_pkg::*;

  logic [DataW-1:0] mem_q [StackDepth];
  logic [DataW-1:0] rd_data_q;
  logic [PtrW-1:0]  rd_addr;
  logic             rd_en;
  logic [PtrW-1:0]  wr_addr;
  logic [DataW-1:0] wr_data;
  logic             wr_en;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CntW-1:0]  depth_q, depth_d;
  logic             err_q, err_d;
  logic [DataW-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic             und_q, und_d, ovf_q, ovf_d, dz_q, dz_d, av_q, av_d;
  logic [DataW-1:0] ans_q, ans_d;
  logic signed [63:0] prod_q, prod_d;
  logic             div_start;
  logic [63:0]      div_num, quot;
  logic [31:0]      div_den, rem;
  logic             div_done;
  logic             neg_q, neg_d;

  rpn_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  logic signed [65:0] sres;
  logic [DataW-1:0]   amag, bmag;
  logic signed [64:0] qs, pq;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    depth_d   = depth_q;
    err_d     = err_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    und_d     = und_q;
    ovf_d     = ovf_q;
    dz_d      = dz_q;
    av_d      = av_q;
    ans_d     = ans_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    cmd_pop_o = 1'b0;
    strobe_o  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    sres      = '0;
    amag      = a_q[31] ? (~a_q + 32'd1) : a_q;
    bmag      = b_q[31] ? (~b_q + 32'd1) : b_q;
    div_num   = cmd_q.is_mod ? {32'd0, amag} : {16'd0, amag, 16'd0};
    div_den   = bmag;
    qs        = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    pq        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          und_d = 1'b0;
          ovf_d = 1'b0;
          dz_d  = 1'b0;
          av_d  = 1'b0;
          ans_d = '0;
          a_d   = '0;
          b_d   = '0;
          unique case (cmd_i.op)
            OP_PUSH: begin
              if (depth_q == CntW'(StackDepth)) begin
                ovf_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = depth_q[PtrW-1:0];
                wr_data = cmd_i.operand;
                depth_d = depth_q + 1'b1;
              end
              state_d = ST_DONE;
            end
            OP_CLEAR: begin
              depth_d = '0;
              state_d = ST_DONE;
            end
            OP_BAD: begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end
            OP_EOL: begin
              if (err_q) begin
                err_d   = 1'b0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_RD_B;
              end
            end
            default: state_d = ST_RD_B;
          endcase
        end
      end
      ST_RD_B: begin
        if (depth_q == '0) begin
          if (cmd_q.op != OP_PEEK) begin
            und_d = 1'b1;
          end else begin
            und_d = 1'b1;
          end
          b_d = '0;
          state_d = ST_EXEC;
          // A zero divisor leaves the dividend in place.
          if ((cmd_q.op == OP_BINARY && cmd_q.arith != AR_DIVMOD)
              || cmd_q.op == OP_SWAP) begin
            state_d = ST_RD_A;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = PtrW'(depth_q - 1'b1);
          if (cmd_q.op != OP_PEEK) begin
            depth_d = depth_q - 1'b1;
          end
          state_d = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        b_d = rd_data_q;
        if ((cmd_q.op == OP_BINARY || cmd_q.op == OP_SWAP)
            && !(cmd_q.op == OP_BINARY && cmd_q.arith == AR_DIVMOD
                 && rd_data_q == '0)) begin
          state_d = ST_RD_A;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_RD_A: begin
        if (depth_q == '0) begin
          und_d = 1'b1;
          a_d = '0;
          state_d = ST_EXEC;
        end else begin
          rd_en   = 1'b1;
          rd_addr = PtrW'(depth_q - 1'b1);
          depth_d = depth_q - 1'b1;
          state_d = ST_WAIT_A;
        end
      end
      ST_WAIT_A: begin
        a_d = rd_data_q;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd_q.op)
          OP_PEEK, OP_EOL: begin
            av_d = 1'b1;
            ans_d = b_q;
            state_d = ST_DONE;
          end
          OP_DUP: begin
            res_d = b_q;
            a_d = b_q;
            state_d = ST_WRITE2;
          end
          OP_SWAP: begin
            res_d = b_q;
            state_d = ST_WRITE2;
          end
          default: begin
            unique case (cmd_q.arith)
              AR_ADD: begin
                sres = 66'($signed(a_q)) + 66'($signed(b_q));
                res_d = sat64(sres);
                state_d = ST_WRITE2;
              end
              AR_SUB: begin
                sres = 66'($signed(a_q)) - 66'($signed(b_q));
                res_d = sat64(sres);
                state_d = ST_WRITE2;
              end
              AR_MUL: begin
                prod_d = $signed(a_q) * $signed(b_q);
                state_d = ST_MUL;
              end
              default: begin
                if (b_q == '0) begin
                  dz_d = 1'b1;
                  err_d = 1'b1;
                  state_d = ST_DONE;
                end else begin
                  neg_d = cmd_q.is_mod ? a_q[31] : (a_q[31] ^ b_q[31]);
                  div_start = 1'b1;
                  state_d = ST_DIV;
                end
              end
            endcase
          end
        endcase
      end
      ST_MUL: begin
        // Truncate toward zero: bias negatives before the arithmetic shift.
        pq = prod_q[63] ? 65'(prod_q + 64'sd65535) : 65'(prod_q);
        sres = 66'(pq >>> 16);
        res_d = sat64(sres);
        state_d = ST_WRITE2;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        if (cmd_q.is_mod) begin
          res_d = neg_q ? (~rem + 32'd1) : rem;
        end else begin
          res_d = sat64(66'(qs));
        end
        state_d = ST_WRITE2;
      end
      ST_WRITE2: begin
        // Push res; dup and swap follow with a second push of a.
        if (depth_q == CntW'(StackDepth)) begin
          ovf_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = depth_q[PtrW-1:0];
          wr_data = res_q;
          depth_d = depth_q + 1'b1;
        end
        if (cmd_q.op == OP_DUP || cmd_q.op == OP_SWAP) begin
          res_d = a_q;
          cmd_d.op = OP_PUSH;
          state_d = ST_WRITE2;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        strobe_o = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    und_q  <= und_d;
    ovf_q  <= ovf_d;
    dz_q   <= dz_d;
    av_q   <= av_d;
    ans_q  <= ans_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      depth_q <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      err_q   <= err_d;
    end
  end

  assign answer_o       = ans_q;
  assign answer_valid_o = av_q;
  assign underflow_o    = und_q;
  assign overflow_o     = ovf_q;
  assign div_zero_o     = dz_q;
  assign depth_o        = DepthW'(depth_q);

endmodule
`default_nettype wire

// File: rtl/rpn_stack_calculator.sv
`default_nettype none
// Reverse Polish calculator on Q16.16 numbers with a 128-entry operand stack.
// A token beat is taken at a clock edge where start is high and busy is
// low; kind_i selects push, an arithmetic operation, a stack operation, end
// of line or a bad token, and operand_i carries the pushed value.
// Every token yields exactly one result beat: strobe is high for one cycle
// while answer_o, answer_valid_o, the underflow, overflow and divide-by-zero
// flags and the new depth are shown. The receiver cannot stall results.
// A front stage classifies tokens into a two-entry queue; the back stage runs
// them one at a time against a single-port stack memory. A push, clear, bad
// token or end of line with an error pending goes straight to its result
// beat; other tokens first read their operands from the stack, and divide
// or remainder wait on the bit-serial 64-step divider.
// Tokens queue while the back stage works.
// Reset empties the stack, clears the pending error and the queue; stack
// contents are not cleared and need no clearing pass.
module rpn_stack_calculator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  kind_i,
  input  wire logic [31:0] operand_i,
  output logic             strobe,
  output logic [31:0]      answer_o,
  output logic             answer_valid_o,
  output logic             underflow_o,
  output logic             overflow_o,
  output logic             div_zero_o,
  output logic [7:0]       depth_o
);
  import rpn_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  rpn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .operand_i   (operand_i),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  rpn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .strobe_o       (strobe),
    .answer_o       (answer_o),
    .answer_valid_o (answer_valid_o),
    .underflow_o    (underflow_o),
    .overflow_o     (overflow_o),
    .div_zero_o     (div_zero_o),
    .depth_o        (depth_o)
  );

  // The back stage never takes a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

  // Depth never exceeds the stack size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) depth_o <= 8'(StackDepth))
    else $error("stack depth out of range");

  // A result beat lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe |=> !strobe)
    else $error("result strobe held");

  // Divide by zero never comes with an answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && div_zero_o |-> !answer_valid_o)
    else $error("answer on divide by zero");

endmodule
`default_nettype wire

// File: verif/rpn_stack_calculator_test.sv
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_test;
  import rpn_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 200;

  typedef struct {
    kind_e       kind;
    logic [31:0] operand;
  } token_t;

  typedef struct {
    logic [31:0] answer;
    logic        answer_valid;
    logic        underflow;
    logic        overflow;
    logic        div_zero;
    logic [7:0]  depth;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [3:0]  kind_i = '0;
  logic [31:0] operand_i = '0;
  wire         busy;
  wire         strobe;
  wire  [31:0] answer_o;
  wire         answer_valid_o;
  wire         underflow_o;
  wire         overflow_o;
  wire         div_zero_o;
  wire  [7:0]  depth_o;

  rpn_stack_calculator DUT (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .operand_i, .strobe, .answer_o,
    .answer_valid_o, .underflow_o, .overflow_o, .div_zero_o, .depth_o
  );

  always #1 clk_i = ~clk_i;

  // Tokens waiting to be driven, and outcomes waiting to be seen on the
  // result port, oldest first.
  token_t   token_queue[$];
  outcome_t outcome_queue[$];

  // The predictor's own copy of the calculator state.
  logic [31:0] calc_stack[StackDepth];
  int unsigned calc_depth;
  logic        calc_error;
  logic        saw_under, saw_over;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          stimulus_done;
  bit          hold_until_empty;
  bit          calm_stretch;
  int unsigned driven_count;

  function automatic logic [31:0] saturate(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fff_ffff;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] stack_pop();
    if (calc_depth == 0) begin
      saw_under = 1'b1;
      return '0;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  function automatic void stack_push(input logic [31:0] v);
    if (calc_depth >= StackDepth) begin
      saw_over = 1'b1;
      return;
    end
    calc_stack[calc_depth] = v;
    calc_depth++;
  endfunction

  // Applies one token to the predicted state and returns what the block
  // should report for it. Divide and remainder truncate toward zero, which
  // is what SystemVerilog signed division does, so the remainder follows
  // the sign of the dividend.
  function automatic outcome_t evaluate_token(input token_t t);
    outcome_t o;
    logic signed [65:0] a, b;
    logic [31:0] x, y;
    o = '{default: '0};
    saw_under = 1'b0;
    saw_over = 1'b0;
    case (t.kind)
      KIND_PUSH: stack_push(t.operand);
      KIND_ADD, KIND_SUB, KIND_MUL: begin
        b = $signed(stack_pop());
        a = $signed(stack_pop());
        if (t.kind == KIND_ADD) stack_push(saturate(a + b));
        else if (t.kind == KIND_SUB) stack_push(saturate(a - b));
        else stack_push(saturate((a * b) / 66'sd65536));
      end
      KIND_DIV, KIND_MOD: begin
        b = $signed(stack_pop());
        if (b == 0) begin
          o.div_zero = 1'b1;
          calc_error = 1'b1;
        end else begin
          a = $signed(stack_pop());
          if (t.kind == KIND_DIV) stack_push(saturate((a * 66'sd65536) / b));
          else stack_push(saturate(a % b));
        end
      end
      KIND_CLEAR: calc_depth = 0;
      KIND_PEEK: begin
        o.answer_valid = 1'b1;
        if (calc_depth == 0) saw_under = 1'b1;
        else o.answer = calc_stack[calc_depth-1];
      end
      KIND_DUP: begin
        x = stack_pop();
        stack_push(x);
        stack_push(x);
      end
      KIND_SWAP: begin
        x = stack_pop();
        y = stack_pop();
        stack_push(x);
        stack_push(y);
      end
      KIND_EOL: begin
        if (calc_error) calc_error = 1'b0;
        else begin
          o.answer = stack_pop();
          o.answer_valid = 1'b1;
        end
      end
      default: calc_error = 1'b1;
    endcase
    o.underflow = saw_under;
    o.overflow = saw_over;
    o.depth = calc_depth[7:0];
    return o;
  endfunction

  // Driver: offers the next queued token, dropping start only when no
  // further token goes out in this beat. The prediction is made at the edge
  // where the block takes the token.
  always @(posedge clk_i) begin
    token_t t;
    if (rst_ni) begin
      if (start && !busy) begin
        t.kind = kind_e'(kind_i);
        t.operand = operand_i;
        outcome_queue.push_back(evaluate_token(t));
        driven_count++;
      end
      if (!(start && busy)) begin
        if (token_queue.size() != 0 && !(hold_until_empty && outcome_queue.size() != 0)
            && (calm_stretch || $urandom_range(99) >= 8)) begin
          t = token_queue.pop_front();
          start <= 1'b1;
          kind_i <= t.kind;
          operand_i <= t.operand;
        end else begin
          start <= 1'b0;
          kind_i <= $urandom_range(15);
          operand_i <= $urandom;
        end
      end
    end
  end

  // Monitor: every strobe beat is checked against the oldest outcome.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && strobe) begin
      if (outcome_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result beat, answer %h depth %0d", answer_o, depth_o);
      end else begin
        e = outcome_queue.pop_front();
        if (answer_o !== e.answer || answer_valid_o !== e.answer_valid ||
            underflow_o !== e.underflow || overflow_o !== e.overflow ||
            div_zero_o !== e.div_zero || depth_o !== e.depth) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected ans %h v%b u%b o%b z%b d%0d, got ans %h v%b u%b o%b z%b d%0d",
                     e.answer, e.answer_valid, e.underflow, e.overflow, e.div_zero, e.depth,
                     answer_o, answer_valid_o, underflow_o, overflow_o, div_zero_o, depth_o);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a token nor a result beat moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe || stimulus_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && token_queue.size() != 0) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_token(input kind_e k, input logic [31:0] v = '0);
    token_t t;
    t.kind = k;
    t.operand = v;
    token_queue.push_back(t);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom_range(2) == 0 ? 32'h0 : 32'hffff_ffff;
      2: return $signed($urandom_range(16)) - 8 <<< 16;
      3: return $urandom & 32'h000f_ffff | ($urandom_range(1) ? 32'hfff0_0000 : 0);
      default: return $urandom;
    endcase
  endfunction

  // One well-formed expression: two to five pushes, one to four operators with an occasional peek, then end of line.
  function automatic void add_expression();
    int unsigned n;
    n = $urandom_range(1, 4);
    add_token(KIND_PUSH, random_value());
    repeat (n) begin
      add_token(KIND_PUSH, $urandom_range(9) == 0 ? 32'h0 : random_value());
      add_token(kind_e'($urandom_range(KIND_ADD, KIND_MOD)));
      if ($urandom_range(5) == 0) add_token(KIND_PEEK);
    end
    add_token(KIND_EOL);
  endfunction

  initial begin
    int unsigned i;
    calc_depth = 0;
    calc_error = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    hold_until_empty = 1'b0;
    calm_stretch = 1'b0;
    driven_count = 0;
    foreach (calc_stack[k]) calc_stack[k] = '0;

    // Directed: empty-stack pops, extremes, every operation, zero divisor,
    // pending error on end of line, bad and unused kinds.
    add_token(KIND_PEEK);
    add_token(KIND_EOL);
    add_token(KIND_ADD);
    add_token(KIND_DUP);
    add_token(KIND_SWAP);
    add_token(KIND_PUSH, 32'h7fff_ffff);
    add_token(KIND_SWAP);
    add_token(KIND_PUSH, 32'h7fff_ffff);
    add_token(KIND_ADD);
    add_token(KIND_PUSH, 32'h8000_0000);
    add_token(KIND_SUB);
    add_token(KIND_PUSH, 32'h8000_0000);
    add_token(KIND_MUL);
    add_token(KIND_PUSH, 32'h0);
    add_token(KIND_DIV);
    add_token(KIND_EOL);
    add_token(KIND_PUSH, 32'hffff_ffff);
    add_token(KIND_MOD);
    add_token(KIND_PUSH, 32'h0003_0000);
    add_token(KIND_DIV);
    add_token(KIND_BAD);
    add_token(kind_e'(4'd15));
    add_token(KIND_EOL);
    add_token(KIND_CLEAR);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the stack past full so overflow and a full duplicate are seen,
    // then read it back down with peeks and end-of-line pops.
    for (i = 0; i < StackDepth + 2; i++) add_token(KIND_PUSH, $urandom);
    add_token(KIND_DUP);
    add_token(KIND_SWAP);
    for (i = 0; i < 20; i++) add_token($urandom_range(1) ? KIND_PEEK : KIND_EOL);
    add_token(KIND_CLEAR);

    // Random part: mostly expressions, with noise and broken sequences.
    while (token_queue.size() < 1950) begin
      case ($urandom_range(9))
        0: add_token(kind_e'($urandom_range(KIND_CLEAR, 15)), $urandom);
        1: add_token(kind_e'($urandom_range(15)), random_value());
        default: add_expression();
      endcase
    end

    // Hold the sender until every result is back, then release it for a
    // stretch without idling.
    wait (token_queue.size() < 1200);
    hold_until_empty = 1'b1;
    wait (outcome_queue.size() == 0);
    @(posedge clk_i);
    hold_until_empty = 1'b0;
    calm_stretch = 1'b1;
    wait (token_queue.size() < 900);
    calm_stretch = 1'b0;

    wait (token_queue.size() == 0 && !start);
    wait (outcome_queue.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    stimulus_done = 1'b1;
    if (mismatch_count == 0 && outcome_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guards the drain phase, where the watchdog no longer looks at the queue.
  initial begin
    wait (token_queue.size() == 0 && rst_ni);
    repeat (WatchdogLimit * 4) @(posedge clk_i);
    if (outcome_queue.size() != 0 || start) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
`default_nettype wire
